[sv/nlp_pkg.sv]
// Package for the numeric literal parser: payload types, base codes and the token format.
package nlp_pkg;

    // Accumulator width; the value port stays 64 bits and is zero-extended
    localparam int VALUE_BITS = 64;

    // Base codes carried in a result
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_US  = 8'h5F;

    // One input character request
    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } char_t;

    // One result request
    typedef struct packed {
        logic [63:0] value;
        logic        ok;
        logic [1:0]  base_code;
        logic [7:0]  length;
    } result_t;

    // Classified character passed from front to back
    typedef struct packed {
        logic       start;
        logic       is_x;
        logic       is_us;
        logic       is_pct;
        logic       is_digit;   // any hex digit, either case
        logic [3:0] dig;
    } tok_t;

endpackage

[sv/nlp_front.sv]
// Front end: classifies each incoming character into a token.
module nlp_front (
    input  nlp_pkg::char_t char_in,
    output nlp_pkg::tok_t  tok
);
    import nlp_pkg::*;

    logic [7:0] c;

    assign c = char_in.ch;

    // Character classes and hex digit value
    always_comb
    begin
        tok.start    = char_in.start_req;
        tok.is_x     = (c == CH_X);
        tok.is_us    = (c == CH_US);
        tok.is_pct   = (c == CH_PCT);
        tok.is_digit = 1'b0;
        tok.dig      = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            tok.is_digit = 1'b1;
            tok.dig      = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            tok.is_digit = 1'b1;
            tok.dig      = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            tok.is_digit = 1'b1;
            tok.dig      = 4'(c - 8'h37);
        end
    end

endmodule

[sv/nlp_fifo.sv]
// Two-entry token queue between the front end and the back end.
module nlp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          full,
    input  nlp_pkg::tok_t wr_tok,
    output logic          rd_valid,
    input  logic          rd_pop,
    output nlp_pkg::tok_t rd_tok
);
    import nlp_pkg::*;

    tok_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_tok   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_tok;
    end

endmodule

[sv/nlp_back.sv]
// Back end: base selection, accumulation and result register.
module nlp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tok_valid,
    output logic             tok_pop,
    input  nlp_pkg::tok_t    tok,
    output logic             result_valid,
    input  logic             result_stall,
    output nlp_pkg::result_t result_data
);
    import nlp_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ZERO = 3'd1;
    localparam logic [2:0] MODE_DEC  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_OCT  = 3'd4;
    localparam logic [2:0] MODE_BIN  = 3'd5;

    logic [2:0]            mode_reg, mode_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  seen_reg, seen_next;
    logic [7:0]            cons_reg, cons_next;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [2:0]            work_mode;
    logic [VALUE_BITS-1:0] scaled;
    logic                  dig_ok;
    logic [1:0]            work_base;
    logic [7:0]            cons_bump;
    logic                  emit;
    logic [1:0]            emit_base;
    logic                  emit_seen;

    // Pop whenever the result register is free or being drained
    assign tok_pop      = tok_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // A leading zero not followed by 'x' continues as octal
    assign work_mode = (mode_reg == MODE_ZERO) ? MODE_OCT : mode_reg;
    assign cons_bump = (cons_reg == 8'hFF) ? cons_reg : cons_reg + 8'd1;

    // Radix decode: shifted accumulator, digit range and base code
    always_comb
    begin
        unique case (work_mode)
            MODE_HEX:
            begin
                scaled    = acc_reg << 4;
                dig_ok    = tok.is_digit;
                work_base = BASE_HEX;
            end
            MODE_OCT:
            begin
                scaled    = acc_reg << 3;
                dig_ok    = tok.is_digit && (tok.dig < 4'd8);
                work_base = BASE_OCT;
            end
            MODE_BIN:
            begin
                scaled    = acc_reg << 1;
                dig_ok    = tok.is_digit && (tok.dig < 4'd2);
                work_base = BASE_BIN;
            end
            default:
            begin
                scaled    = (acc_reg << 3) + (acc_reg << 1);
                dig_ok    = tok.is_digit && (tok.dig < 4'd10);
                work_base = BASE_DEC;
            end
        endcase
    end

    // Literal state update for one token
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        cons_next = cons_reg;
        emit      = 1'b0;
        emit_base = BASE_DEC;
        emit_seen = seen_reg;
        if (tok.start)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            seen_next = 1'b0;
            cons_next = 8'd0;
            emit_seen = 1'b0;
            if (tok.is_digit && tok.dig == 4'd0)
            begin
                mode_next = MODE_ZERO;
                seen_next = 1'b1;
                cons_next = 8'd1;
            end
            else if (tok.is_pct)
            begin
                mode_next = MODE_BIN;
                cons_next = 8'd1;
            end
            else if (tok.is_us)
            begin
                mode_next = MODE_DEC;
                cons_next = 8'd1;
            end
            else if (tok.is_digit && tok.dig < 4'd10)
            begin
                mode_next = MODE_DEC;
                acc_next  = VALUE_BITS'(tok.dig);
                seen_next = 1'b1;
                cons_next = 8'd1;
            end
            else
                emit = 1'b1;
        end
        else if (mode_reg != MODE_IDLE)
        begin
            if (mode_reg == MODE_ZERO && tok.is_x)
            begin
                mode_next = MODE_HEX;
                acc_next  = '0;
                seen_next = 1'b0;
                cons_next = cons_bump;
            end
            else if (tok.is_us)
            begin
                mode_next = work_mode;
                cons_next = cons_bump;
            end
            else if (dig_ok)
            begin
                mode_next = work_mode;
                acc_next  = scaled + VALUE_BITS'(tok.dig);
                seen_next = 1'b1;
                cons_next = cons_bump;
            end
            else
            begin
                emit      = 1'b1;
                emit_base = work_base;
                mode_next = MODE_IDLE;
                acc_next  = '0;
                seen_next = 1'b0;
                cons_next = 8'd0;
            end
        end
    end

    // Literal state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            cons_reg <= 8'd0;
        end
        else if (tok_pop)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            cons_reg <= cons_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tok_pop && emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && emit)
        begin
            out_reg.value     <= emit_seen ? 64'(acc_reg) : 64'd0;
            out_reg.ok        <= emit_seen;
            out_reg.base_code <= emit_base;
            out_reg.length    <= emit_seen ? cons_reg : 8'd0;
        end
    end

endmodule

[sv/numeric_literal_parser.sv]
// Top level of the streaming numeric literal parser.
// Takes one character request per cycle, sustained, and gives one result per literal
// (hex "0x", binary "%", octal leading "0", else decimal; underscores skipped). A
// character is classified on entry and written to a two-entry queue; the back end
// takes one token per cycle, updating the accumulator by shifts and an add, and
// writes a result into an output register on the first character that does not
// belong. result_valid is registered: the terminating character passes through the
// queue and then the result register. Input stalls only when the queue is full,
// which happens only while the result register is held by a stalled consumer.
module numeric_literal_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_stall,
    input  nlp_pkg::char_t   char_data,
    output logic             result_valid,
    input  logic             result_stall,
    output nlp_pkg::result_t result_data
);
    import nlp_pkg::*;

    tok_t front_tok;
    tok_t q_tok;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign char_stall = q_full;

    // Classification
    nlp_front u_front (
        .char_in (char_data),
        .tok     (front_tok)
    );

    // Token queue
    nlp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (char_valid),
        .full     (q_full),
        .wr_tok   (front_tok),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_tok   (q_tok)
    );

    // Accumulation and results
    nlp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_valid),
        .tok_pop      (q_pop),
        .tok          (q_tok),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
